// ===== hdl/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types and constants for the button press duration classifier.
// ----------------------------------------------------------------------------
package bpdc_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int THRESH_BITS    = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int IN_DATA_BITS   = 8;
	localparam int OUT_DATA_BITS  = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_LEVEL     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MEDIUM_TICKS   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_TICKS     = 2'd3;

	// reset values of the configuration registers
	localparam logic                   IDLE_LEVEL_RST     = 1'b1;
	localparam logic [THRESH_BITS-1:0] DEBOUNCE_TICKS_RST = 16'd50;
	localparam logic [THRESH_BITS-1:0] MEDIUM_TICKS_RST   = 16'd1000;
	localparam logic [THRESH_BITS-1:0] LONG_TICKS_RST     = 16'd3000;

	typedef struct packed {
		logic                   idle_level;
		logic [THRESH_BITS-1:0] debounce_ticks;
		logic [THRESH_BITS-1:0] medium_ticks;
		logic [THRESH_BITS-1:0] long_ticks;
	} cfg_t;

	typedef struct packed {
		logic button_level;
		logic ack_short;
		logic ack_medium;
		logic ack_long;
	} item_t;

	typedef struct packed {
		logic toggle_out;
		logic held_debounced;
		logic held_medium;
		logic held_long;
		logic short_event;
		logic medium_event;
		logic long_event;
	} result_t;

endpackage

// ===== hdl/bpdc_core.sv =====
// ----------------------------------------------------------------------------
// bpdc_core
// Press state, saturating hold counter, classification and sticky event flags.
// ----------------------------------------------------------------------------
module bpdc_core #(
	parameter int TIMER_BITS = bpdc_pkg::TIMER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  bpdc_pkg::item_t   item,
	input  bpdc_pkg::cfg_t    cfg,
	output bpdc_pkg::result_t result
);
	import bpdc_pkg::*;

	localparam int CMP_BITS = (TIMER_BITS > THRESH_BITS) ? TIMER_BITS : THRESH_BITS;

	logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic                  press_q, press_d;
	logic                  deb_q, deb_d;
	logic                  tog_q, tog_d;
	logic                  med_q, med_d;
	logic                  lng_q, lng_d;
	logic                  sflag_q, sflag_d;
	logic                  mflag_q, mflag_d;
	logic                  lflag_q, lflag_d;
	logic                  pressing;
	logic [CMP_BITS-1:0]   cnt_x, dur_x, deb_x, med_x, lng_x;
	logic                  ev_s, ev_m, ev_l;

	assign pressing = (item.button_level != cfg.idle_level);
	assign cnt_inc  = (cnt_q == {TIMER_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	assign deb_x = CMP_BITS'(cfg.debounce_ticks);
	assign med_x = CMP_BITS'(cfg.medium_ticks);
	assign lng_x = CMP_BITS'(cfg.long_ticks);
	// duration on release is the saturated count plus this tick
	assign dur_x = CMP_BITS'(cnt_inc);

	always_comb begin
		cnt_d   = cnt_q;
		press_d = press_q;
		deb_d   = deb_q;
		tog_d   = tog_q;
		med_d   = med_q;
		lng_d   = lng_q;
		ev_s    = 1'b0;
		ev_m    = 1'b0;
		ev_l    = 1'b0;
		cnt_x   = '0;
		if (pressing) begin
			press_d = 1'b1;
			cnt_d   = press_q ? cnt_inc : '0;
			cnt_x   = CMP_BITS'(cnt_d);
			if (cnt_x >= deb_x) begin
				if (!deb_q) begin
					tog_d = ~tog_q;
					deb_d = 1'b1;
				end
				if (cnt_x >= lng_x) lng_d = 1'b1;
				if (cnt_x >= med_x) med_d = 1'b1;
			end
		end else if (press_q) begin
			ev_s    = (dur_x >= deb_x) && (dur_x < med_x);
			ev_m    = (dur_x >= med_x) && (dur_x < lng_x);
			ev_l    = (dur_x >= lng_x);
			press_d = 1'b0;
			cnt_d   = '0;
			deb_d   = 1'b0;
			med_d   = 1'b0;
			lng_d   = 1'b0;
		end
		// a fresh event wins over an acknowledge in the same beat
		sflag_d = ev_s | (sflag_q & ~item.ack_short);
		mflag_d = ev_m | (mflag_q & ~item.ack_medium);
		lflag_d = ev_l | (lflag_q & ~item.ack_long);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			press_q <= 1'b0;
			deb_q   <= 1'b0;
			tog_q   <= IDLE_LEVEL_RST;
			med_q   <= 1'b0;
			lng_q   <= 1'b0;
			sflag_q <= 1'b0;
			mflag_q <= 1'b0;
			lflag_q <= 1'b0;
		end else if (step) begin
			cnt_q   <= cnt_d;
			press_q <= press_d;
			deb_q   <= deb_d;
			tog_q   <= tog_d;
			med_q   <= med_d;
			lng_q   <= lng_d;
			sflag_q <= sflag_d;
			mflag_q <= mflag_d;
			lflag_q <= lflag_d;
		end
	end

	always_comb begin
		result.toggle_out     = tog_d;
		result.held_debounced = deb_d;
		result.held_medium    = med_d;
		result.held_long      = lng_d;
		result.short_event    = sflag_d;
		result.medium_event   = mflag_d;
		result.long_event     = lflag_d;
	end

	// held marks only exist inside a debounced press
	a_med_needs_deb: assert property (@(posedge clk) disable iff (!arst_n)
		(med_q || lng_q) |-> deb_q)
		else $error("medium or long mark without debounce mark");

	a_deb_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		deb_q |-> press_q)
		else $error("debounce mark outside a press");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !pressing && press_q) |=> (!press_q && cnt_q == '0 && !deb_q))
		else $error("release did not clear press state");

	a_toggle_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(tog_q))
		else $error("toggle level moved without a beat");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		(step && press_q && !pressing && cfg.debounce_ticks <= cfg.medium_ticks
			&& cfg.medium_ticks <= cfg.long_ticks) |-> $onehot0({ev_s, ev_m, ev_l}))
		else $error("several events from one release with ordered thresholds");

endmodule

// ===== hdl/button_press_duration_classifier_top.sv =====
// ----------------------------------------------------------------------------
// button_press_duration_classifier_top
// Debounced button with toggle output, live hold marks and sticky press events.
// ----------------------------------------------------------------------------
// One input beat per sample tick gives exactly one output beat. A beat is taken
// every clock cycle while the output side keeps up. The accepting edge loads the
// input register; the item then moves on, updating the core state and loading the
// output register, once that register is free or being drained.
// The rate is set by the update of the press counter and flags on each beat.
// Input and output are parted by registers, so a new beat can enter an empty
// input register while a finished result still waits. Configuration writes
// are taken at any time and are meant to happen only while the block is idle.
module button_press_duration_classifier_top #(
	parameter int TIMER_BITS = bpdc_pkg::TIMER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [0] button_level, [1] ack_short, [2] ack_medium, [3] ack_long, [7:4] zero
	input  logic [bpdc_pkg::IN_DATA_BITS-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] toggle_out, [1] held_debounced, [2] held_medium, [3] held_long,
	// [4] short_event, [5] medium_event, [6] long_event, [7] zero
	output logic [bpdc_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bpdc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import bpdc_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_level     <= IDLE_LEVEL_RST;
			cfg_q.debounce_ticks <= DEBOUNCE_TICKS_RST;
			cfg_q.medium_ticks   <= MEDIUM_TICKS_RST;
			cfg_q.long_ticks     <= LONG_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IDLE_LEVEL:     cfg_q.idle_level     <= cfg_data[0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[THRESH_BITS-1:0];
				REG_MEDIUM_TICKS:   cfg_q.medium_ticks   <= cfg_data[THRESH_BITS-1:0];
				REG_LONG_TICKS:     cfg_q.long_ticks     <= cfg_data[THRESH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// item moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.button_level <= s_tdata[0];
			item_s1.ack_short    <= s_tdata[1];
			item_s1.ack_medium   <= s_tdata[2];
			item_s1.ack_long     <= s_tdata[3];
		end
		if (advance) res_s2 <= res;
	end

	bpdc_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.long_event, res_s2.medium_event, res_s2.short_event,
		res_s2.held_long, res_s2.held_medium, res_s2.held_debounced, res_s2.toggle_out};

endmodule
